@@ rtl/core/assert_macros.svh @@
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition at every clock edge outside reset.
`define ASSERT_CLK(lbl, cond, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) else $error(msg);

// Check that a condition holds in the cycle after a trigger.
`define ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |=> (post)) else $error(msg);

`endif

@@ rtl/core/pfx_pkg.sv @@
`default_nettype none

package pfx_pkg;

    localparam int DATA_W          = 32;
    localparam int CHAR_W          = 8;
    localparam int STATUS_W        = 2;
    localparam int DEF_STACK_DEPTH = 16;

    localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CHAR_MUL   = 8'h2A;
    localparam logic [CHAR_W-1:0] CHAR_DIV   = 8'h2F;
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;

    typedef enum logic [STATUS_W-1:0] {
        ERR_NONE  = 2'd0,
        ERR_UNDER = 2'd1,
        ERR_OVER  = 2'd2,
        ERR_DIV0  = 2'd3
    } err_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RD_A,
        ST_RD_B,
        ST_LD_B,
        ST_EXEC,
        ST_DIV,
        ST_PUSH,
        ST_FIN_RD,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic accept;
        logic pop;
        logic load_a;
        logic load_b;
        logic exec;
        logic div_load;
        logic push;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic in_digit;
        logic last;
        logic div_go;
        logic div_done;
        logic out_free;
    } stat_t;

endpackage

`default_nettype wire

@@ rtl/core/pfx_div.sv @@
`default_nettype none

module pfx_div (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      start,
    input  wire logic [pfx_pkg::DATA_W-1:0] dividend,
    input  wire logic [pfx_pkg::DATA_W-1:0] divisor,
    output logic                           done,
    output logic [pfx_pkg::DATA_W-1:0]      quotient
);
    import pfx_pkg::*;

    localparam int CNT_W = $clog2(DATA_W);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [DATA_W-1:0] rem_reg, rem_next;
    logic [DATA_W-1:0] quo_reg, quo_next;
    logic [DATA_W-1:0] dvs_reg, dvs_next;
    logic              neg_reg, neg_next;
    logic [DATA_W:0]   shifted;
    logic [DATA_W:0]   diff;
    logic              fits;

    assign shifted = {rem_reg, quo_reg[DATA_W-1]};
    assign diff    = shifted - {1'b0, dvs_reg};
    assign fits    = !diff[DATA_W];

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        neg_next  = neg_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(DATA_W - 1);
            rem_next  = '0;
            neg_next  = dividend[DATA_W-1] ^ divisor[DATA_W-1];
            quo_next  = dividend[DATA_W-1] ? (-dividend) : dividend;
            dvs_next  = divisor[DATA_W-1] ? (-divisor) : divisor;
        end else if (busy_reg) begin
            rem_next = fits ? diff[DATA_W-1:0] : shifted[DATA_W-1:0];
            quo_next = {quo_reg[DATA_W-2:0], fits};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        cnt_reg <= cnt_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
        neg_reg <= neg_next;
    end

    assign done     = done_reg;
    assign quotient = neg_reg ? (-quo_reg) : quo_reg;

endmodule

`default_nettype wire

@@ rtl/core/pfx_datapath.sv @@
`default_nettype none

module pfx_datapath #(
    parameter int STACK_DEPTH = pfx_pkg::DEF_STACK_DEPTH
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire pfx_pkg::cmd_t               cmd,
    output pfx_pkg::stat_t                   stat,
    input  wire logic [pfx_pkg::CHAR_W-1:0]   s_tdata,
    input  wire logic                        s_tlast,
    input  wire logic                        m_tready,
    output logic                             m_tvalid,
    output logic [pfx_pkg::DATA_W-1:0]        m_tdata,
    output logic [pfx_pkg::STATUS_W-1:0]      m_tuser
);
    import pfx_pkg::*;

    `include "assert_macros.svh"

    localparam int DEPTH_W = $clog2(STACK_DEPTH + 1);
    localparam int IDX_W   = $clog2(STACK_DEPTH);

    logic [DATA_W-1:0]  mem [STACK_DEPTH];
    logic [DATA_W-1:0]  rdata_reg;
    logic [DATA_W-1:0]  a_reg, a_next;
    logic [DATA_W-1:0]  b_reg, b_next;
    logic [DATA_W-1:0]  res_reg, res_next;
    logic [DATA_W-1:0]  out_val_reg, out_val_next;
    logic [CHAR_W-1:0]  ch_reg, ch_next;
    logic               last_reg, last_next;
    logic               ok_reg, ok_next;
    logic [DEPTH_W-1:0] depth_reg, depth_next;
    err_t               err_reg, err_next;
    err_t               out_st_reg, out_st_next;
    logic               m_valid_reg, m_valid_next;

    logic               has_top;
    logic               can_push;
    logic [DEPTH_W-1:0] depth_dec;
    logic [IDX_W-1:0]   rd_idx;
    logic [IDX_W-1:0]   wr_idx;
    logic               rd_en;
    logic               wr_en;
    logic [DATA_W-1:0]  pop_val;
    err_t               flag;
    logic               div_zero;
    logic               div_start;
    logic               div_done;
    logic [DATA_W-1:0]  div_q;

    assign has_top   = depth_reg != '0;
    assign can_push  = depth_reg < DEPTH_W'(STACK_DEPTH);
    assign depth_dec = depth_reg - 1'b1;
    assign rd_idx    = depth_dec[IDX_W-1:0];
    assign wr_idx    = depth_reg[IDX_W-1:0];
    assign rd_en     = cmd.pop && has_top;
    assign wr_en     = cmd.push && can_push;
    assign pop_val   = ok_reg ? rdata_reg : '0;
    assign div_zero  = a_reg == '0;
    assign div_start = cmd.exec && (ch_reg == CHAR_DIV) && !div_zero;

    pfx_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (b_reg),
        .divisor  (a_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    always_comb begin
        a_next       = a_reg;
        b_next       = b_reg;
        res_next     = res_reg;
        out_val_next = out_val_reg;
        ch_next      = ch_reg;
        last_next    = last_reg;
        ok_next      = ok_reg;
        depth_next   = depth_reg;
        err_next     = err_reg;
        out_st_next  = out_st_reg;
        m_valid_next = m_valid_reg;
        flag         = ERR_NONE;

        if (cmd.accept) begin
            ch_next   = s_tdata;
            last_next = s_tlast;
            res_next  = DATA_W'(s_tdata[3:0]);
        end
        if (cmd.pop) begin
            ok_next = has_top;
            if (has_top) begin
                depth_next = depth_dec;
            end else begin
                flag = ERR_UNDER;
            end
        end
        if (cmd.load_a) begin
            a_next = pop_val;
        end
        if (cmd.load_b) begin
            b_next = pop_val;
        end
        if (cmd.exec) begin
            case (ch_reg)
                CHAR_PLUS:  res_next = b_reg + a_reg;
                CHAR_MINUS: res_next = b_reg - a_reg;
                CHAR_MUL:   res_next = b_reg * a_reg;
                CHAR_DIV: begin
                    res_next = '0;
                    if (div_zero) begin
                        flag = ERR_DIV0;
                    end
                end
                default:    res_next = '0;
            endcase
        end
        if (cmd.div_load) begin
            res_next = div_q;
        end
        if (cmd.push) begin
            if (can_push) begin
                depth_next = depth_reg + 1'b1;
            end else begin
                flag = ERR_OVER;
            end
        end
        if (err_reg == ERR_NONE && flag != ERR_NONE) begin
            err_next = flag;
        end
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end
        if (cmd.emit) begin
            out_val_next = pop_val;
            out_st_next  = err_reg;
            m_valid_next = 1'b1;
            depth_next   = '0;
            err_next     = ERR_NONE;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_idx] <= res_reg;
        end
        if (rd_en) begin
            rdata_reg <= mem[rd_idx];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            depth_reg   <= '0;
            err_reg     <= ERR_NONE;
            m_valid_reg <= 1'b0;
        end else begin
            depth_reg   <= depth_next;
            err_reg     <= err_next;
            m_valid_reg <= m_valid_next;
        end
        a_reg       <= a_next;
        b_reg       <= b_next;
        res_reg     <= res_next;
        out_val_reg <= out_val_next;
        out_st_reg  <= out_st_next;
        ch_reg      <= ch_next;
        last_reg    <= last_next;
        ok_reg      <= ok_next;
    end

    always_comb begin
        stat.in_digit = s_tdata inside {[CHAR_ZERO:CHAR_NINE]};
        stat.last     = last_reg;
        stat.div_go   = (ch_reg == CHAR_DIV) && !div_zero;
        stat.div_done = div_done;
        stat.out_free = !m_valid_reg || m_tready;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = out_val_reg;
    assign m_tuser  = out_st_reg;

    `ASSERT_CLK(a_depth_bound, depth_reg <= DEPTH_W'(STACK_DEPTH), "stack depth past capacity")
    `ASSERT_NEXT(a_emit_clears, cmd.emit, depth_reg == '0 && err_reg == ERR_NONE, "emit left state")
    `ASSERT_NEXT(a_err_sticky, err_reg != ERR_NONE && !cmd.emit, err_reg == $past(err_reg), "error code changed")

endmodule

`default_nettype wire

@@ rtl/core/pfx_ctrl.sv @@
`default_nettype none

module pfx_ctrl (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           s_tvalid,
    output logic                s_tready,
    input  wire pfx_pkg::stat_t stat,
    output pfx_pkg::cmd_t       cmd
);
    import pfx_pkg::*;

    `include "assert_macros.svh"

    state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = stat.in_digit ? ST_PUSH : ST_RD_A;
                end
            end
            ST_RD_A:   state_next = ST_RD_B;
            ST_RD_B:   state_next = ST_LD_B;
            ST_LD_B:   state_next = ST_EXEC;
            ST_EXEC:   state_next = stat.div_go ? ST_DIV : ST_PUSH;
            ST_DIV: begin
                if (stat.div_done) begin
                    state_next = ST_PUSH;
                end
            end
            ST_PUSH:   state_next = stat.last ? ST_FIN_RD : ST_IDLE;
            ST_FIN_RD: state_next = ST_EMIT;
            ST_EMIT: begin
                if (stat.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd      = '0;
        s_tready = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready   = 1'b1;
                cmd.accept = s_tvalid;
            end
            ST_RD_A:   cmd.pop = 1'b1;
            ST_RD_B: begin
                cmd.pop    = 1'b1;
                cmd.load_a = 1'b1;
            end
            ST_LD_B:   cmd.load_b = 1'b1;
            ST_EXEC:   cmd.exec = 1'b1;
            ST_DIV:    cmd.div_load = stat.div_done;
            ST_PUSH:   cmd.push = 1'b1;
            ST_FIN_RD: cmd.pop = 1'b1;
            ST_EMIT:   cmd.emit = stat.out_free;
            default:   cmd = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    `ASSERT_NEXT(a_accept_leaves_idle, cmd.accept, state_reg != ST_IDLE, "accepted request not taken")

endmodule

`default_nettype wire

@@ rtl/core/postfix_expression_evaluator.sv @@
// Per request: a digit is accepted and pushed; '+', '-', '*', unknown characters and
// '/' by zero pop two operands, execute and push; '/' runs the 32-step iterative
// divider plus handoff before the push. A last request then pops the top into the
// output register, after any wait for m_tready on a pending result. One request is
// in work at a time. Reset (aresetn low, synchronous) empties the stack, clears the
// error code, the controller and m_tvalid; stack contents are not cleared.
`default_nettype none

module postfix_expression_evaluator #(
    parameter int STACK_DEPTH = pfx_pkg::DEF_STACK_DEPTH
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        s_tvalid,
    output logic                             s_tready,
    input  wire logic [pfx_pkg::CHAR_W-1:0]   s_tdata,   // [7:0] char_code
    input  wire logic                        s_tlast,   // end_of_expr
    output logic                             m_tvalid,
    input  wire logic                        m_tready,
    output logic [pfx_pkg::DATA_W-1:0]        m_tdata,   // [31:0] value
    output logic [pfx_pkg::STATUS_W-1:0]      m_tuser    // [1:0] status
);
    import pfx_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    pfx_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    pfx_datapath #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .stat     (stat),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

`default_nettype wire
